[sv/wdh_pkg.sv]
// Shared codes, widths and limits for the weighted drop-head FIFO.
package wdh_pkg;

  localparam int KIND_W   = 3;
  localparam int OUT_ID_W = 16;
  localparam int OUT_WT_W = 16;
  localparam int TOTAL_W  = 20;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DEPART = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEPARTED = 3'd0,
    KIND_ADDED    = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_HIT      = 3'd4,
    KIND_MISS     = 3'd5
  } kind_t;

  // configuration register indexes
  localparam logic CFG_AUTO_EN = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

endpackage

[sv/wdh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/weighted_drop_head_fifo.sv]
// Weighted drop-head FIFO: entries of id and weight held in one RAM, with a running weight total.
// One command is worked at a time. An add first lets auto-dispatch evict entries from the front
// while the new weight would take the total over the limit. A depart reads the head entry, or
// reports empty on an empty store. A find compares entries from the head until one hits or all
// are compared. Every entry read goes through the single registered read port of the entry RAM.
// A result waits while the output register still holds one not yet taken by out_ready. Results
// leave through one output register, so the next command is taken while the last result still
// waits for out_ready. Commands with code 3 are dropped without a result. total_weight saturates at
// 1048575 and entry_count at 31.
module weighted_drop_head_fifo
  import wdh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // commands
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [ID_BITS-1:0]     item_id,
  input  logic [WEIGHT_BITS-1:0] item_weight,
  // results
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_W-1:0]      kind,
  output logic [OUT_ID_W-1:0]    out_id,
  output logic [OUT_WT_W-1:0]    out_weight,
  output logic [TOTAL_W-1:0]     total_weight,
  output logic [COUNT_W-1:0]     entry_count,
  output logic                   last
);

  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_BITS   = WEIGHT_BITS + CNT_BITS;
  localparam int CMP_BITS   = (SUM_BITS + 1 > TOTAL_W + 1) ? SUM_BITS + 1 : TOTAL_W + 1;
  localparam int CCMP_BITS  = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;
  localparam int ENTRY_BITS = ID_BITS + WEIGHT_BITS;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ADD      = 6'b000010,
    ST_DEP      = 6'b000100,
    ST_POP      = 6'b001000,
    ST_FIND_RD  = 6'b010000,
    ST_FIND_CHK = 6'b100000
  } state_t;

  function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  state_t                  state, state_next;
  logic                    auto_en;
  logic [TOTAL_W-1:0]      limit;
  logic [ID_BITS-1:0]      key_id;
  logic [WEIGHT_BITS-1:0]  add_wt;
  logic                    evicting, evicting_next;
  logic [PTR_BITS-1:0]     head, head_next;
  logic [PTR_BITS-1:0]     tail, tail_next;
  logic [PTR_BITS-1:0]     fptr, fptr_next;
  logic [CNT_BITS-1:0]     count, count_next;
  logic [CNT_BITS-1:0]     scan_idx, scan_idx_next;
  logic [SUM_BITS-1:0]     sum, sum_next;

  logic                    ram_we, ram_re;
  logic [PTR_BITS-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0]   ram_rdata;
  logic [ID_BITS-1:0]      rd_id;
  logic [WEIGHT_BITS-1:0]  rd_wt;

  logic                    emit_ok, emit, emit_last;
  kind_t                   emit_kind;
  logic [ID_BITS-1:0]      emit_id;
  logic [WEIGHT_BITS-1:0]  emit_wt;
  logic                    over_limit;
  logic [CMP_BITS-1:0]     sum_wide;
  logic [CCMP_BITS-1:0]    count_wide;

  wdh_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({key_id, add_wt}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_id = ram_rdata[ENTRY_BITS-1 -: ID_BITS];
  assign rd_wt = ram_rdata[WEIGHT_BITS-1:0];

  assign in_ready   = (state == ST_IDLE);
  assign emit_ok    = !out_valid || out_ready;
  assign ram_waddr  = tail;
  assign over_limit = (CMP_BITS'(sum) + CMP_BITS'(add_wt)) > CMP_BITS'(limit);

  always_comb begin
    state_next    = state;
    evicting_next = evicting;
    head_next     = head;
    tail_next     = tail;
    fptr_next     = fptr;
    count_next    = count;
    scan_idx_next = scan_idx;
    sum_next      = sum;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = head;
    emit          = 1'b0;
    emit_last     = 1'b1;
    emit_kind     = KIND_MISS;
    emit_id       = '0;
    emit_wt       = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_ADD:    state_next = ST_ADD;
            CMD_DEPART: state_next = ST_DEP;
            CMD_FIND: begin
              fptr_next     = head;
              scan_idx_next = '0;
              state_next    = ST_FIND_RD;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (auto_en && count != '0 && over_limit) begin
          ram_re        = 1'b1;
          evicting_next = 1'b1;
          state_next    = ST_POP;
        end else if (emit_ok) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (count == CNT_BITS'(QUEUE_DEPTH)) begin
            emit_kind = KIND_FULL;
          end else begin
            emit_kind  = KIND_ADDED;
            emit_id    = key_id;
            emit_wt    = add_wt;
            ram_we     = 1'b1;
            tail_next  = next_slot(tail);
            count_next = count + CNT_BITS'(1);
            sum_next   = sum + SUM_BITS'(add_wt);
          end
        end
      end
      ST_DEP: begin
        if (count == '0) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_kind  = KIND_EMPTY;
            state_next = ST_IDLE;
          end
        end else begin
          ram_re        = 1'b1;
          evicting_next = 1'b0;
          state_next    = ST_POP;
        end
      end
      ST_POP: begin
        // head entry was read on the way into this state; rdata holds until the next read
        if (emit_ok) begin
          emit       = 1'b1;
          emit_kind  = KIND_DEPARTED;
          emit_id    = rd_id;
          emit_wt    = rd_wt;
          emit_last  = !evicting;
          sum_next   = (sum >= SUM_BITS'(rd_wt)) ? sum - SUM_BITS'(rd_wt) : '0;
          count_next = count - CNT_BITS'(1);
          head_next  = next_slot(head);
          state_next = evicting ? ST_ADD : ST_IDLE;
        end
      end
      ST_FIND_RD: begin
        if (scan_idx == count) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_kind  = KIND_MISS;
            state_next = ST_IDLE;
          end
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = fptr;
          state_next = ST_FIND_CHK;
        end
      end
      ST_FIND_CHK: begin
        if (rd_id == key_id) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_kind  = KIND_HIT;
            emit_id    = rd_id;
            emit_wt    = rd_wt;
            state_next = ST_IDLE;
          end
        end else begin
          fptr_next     = next_slot(fptr);
          scan_idx_next = scan_idx + CNT_BITS'(1);
          state_next    = ST_FIND_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // reported totals are those after this result, saturated to the field widths
  assign sum_wide   = CMP_BITS'(sum_next);
  assign count_wide = CCMP_BITS'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      evicting  <= 1'b0;
      head      <= '0;
      tail      <= '0;
      fptr      <= '0;
      count     <= '0;
      scan_idx  <= '0;
      sum       <= '0;
      auto_en   <= 1'b0;
      limit     <= TOTAL_MAX;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      evicting <= evicting_next;
      head     <= head_next;
      tail     <= tail_next;
      fptr     <= fptr_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
      sum      <= sum_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AUTO_EN: auto_en <= cfg_data[0];
          CFG_LIMIT:   limit   <= cfg_data[TOTAL_W-1:0];
          default:     auto_en <= auto_en;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_id <= item_id;
      add_wt <= item_weight;
    end
    if (emit) begin
      kind         <= emit_kind;
      out_id       <= OUT_ID_W'(emit_id);
      out_weight   <= OUT_WT_W'(emit_wt);
      total_weight <= (sum_wide > CMP_BITS'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
      entry_count  <= (count_wide > CCMP_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                            : count_wide[COUNT_W-1:0];
      last         <= emit_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_empty_no_weight: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> sum == '0)
    else $error("empty queue carries weight");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_BITS'(QUEUE_DEPTH)) |-> head == tail)
    else $error("head and tail disagree with count");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> count < CNT_BITS'(QUEUE_DEPTH) && !ram_re)
    else $error("write to a full store or overlapping a read");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$past(emit))
    else $error("result written over a pending transfer");

endmodule

[sim/wdh_checker.sv]
// Result checker for the weighted drop-head FIFO: tracks queue state and compares every result.
module wdh_checker
  import wdh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [15:0]         item_id,
  input  logic [15:0]         item_weight,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [OUT_ID_W-1:0] out_id,
  input  logic [OUT_WT_W-1:0] out_weight,
  input  logic [TOTAL_W-1:0]  total_weight,
  input  logic [COUNT_W-1:0]  entry_count,
  input  logic                last,
  output int                  failures,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t                kind;
    logic [OUT_ID_W-1:0]  id;
    logic [OUT_WT_W-1:0]  weight;
    logic [TOTAL_W-1:0]   total;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } fifo_result_t;

  logic [15:0]        id_mem [QUEUE_DEPTH];
  logic [15:0]        wt_mem [QUEUE_DEPTH];
  int unsigned        head_idx;
  int unsigned        tail_idx;
  int unsigned        held;
  int unsigned        weight_total;
  logic               auto_en;
  logic [TOTAL_W-1:0] weight_cap;
  fifo_result_t       fifo_results_q[$];
  int                 mismatch_cnt;

  assign failures = mismatch_cnt;

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic void log_result(kind_t k, logic [15:0] id, logic [15:0] wt, logic fin);
    fifo_result_t r;
    r.kind   = k;
    r.id     = id;
    r.weight = wt;
    r.total  = (weight_total > 32'(TOTAL_MAX)) ? TOTAL_MAX : weight_total[TOTAL_W-1:0];
    r.count  = (held > 32'(COUNT_MAX)) ? COUNT_MAX : held[COUNT_W-1:0];
    r.last   = fin;
    fifo_results_q.push_back(r);
  endfunction

  function automatic void drop_front(logic fin);
    logic [15:0] id;
    logic [15:0] wt;
    id = id_mem[head_idx];
    wt = wt_mem[head_idx];
    weight_total = (weight_total >= wt) ? weight_total - wt : 0;
    held--;
    head_idx = wrap_next(head_idx);
    log_result(KIND_DEPARTED, id, wt, fin);
  endfunction

  function automatic void run_command(logic [1:0] c, logic [15:0] id, logic [15:0] wt);
    int unsigned p;
    bit hit;
    case (c)
      CMD_ADD: begin
        if (auto_en) begin
          while (held > 0 && weight_total + wt > weight_cap)
            drop_front(1'b0);
        end
        if (held >= QUEUE_DEPTH) begin
          log_result(KIND_FULL, '0, '0, 1'b1);
        end else begin
          id_mem[tail_idx] = id;
          wt_mem[tail_idx] = wt;
          tail_idx = wrap_next(tail_idx);
          held++;
          weight_total += wt;
          log_result(KIND_ADDED, id, wt, 1'b1);
        end
      end
      CMD_DEPART: begin
        if (held > 0) drop_front(1'b1);
        else log_result(KIND_EMPTY, '0, '0, 1'b1);
      end
      CMD_FIND: begin
        p = head_idx;
        hit = 0;
        for (int i = 0; i < held; i++) begin
          if (!hit && id_mem[p] == id) begin
            log_result(KIND_HIT, id_mem[p], wt_mem[p], 1'b1);
            hit = 1;
          end
          p = wrap_next(p);
        end
        if (!hit) log_result(KIND_MISS, '0, '0, 1'b1);
      end
      default: ;  // code 3 is dropped by the block
    endcase
  endfunction

  always @(posedge clk) begin
    fifo_result_t exp_r;
    if (rst) begin
      head_idx     = 0;
      tail_idx     = 0;
      held         = 0;
      weight_total = 0;
      auto_en      = 1'b0;
      weight_cap   = TOTAL_MAX;
      fifo_results_q.delete();
      mismatch_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (fifo_results_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected result kind=%0d id=%h wt=%h total=%0d count=%0d last=%b",
                     $realtime, kind, out_id, out_weight, total_weight, entry_count, last);
          mismatch_cnt++;
        end else begin
          exp_r = fifo_results_q.pop_front();
          if (kind !== exp_r.kind || out_id !== exp_r.id || out_weight !== exp_r.weight ||
              total_weight !== exp_r.total || entry_count !== exp_r.count ||
              last !== exp_r.last) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  exp kind=%0d id=%h wt=%h total=%0d count=%0d last=%b",
                       exp_r.kind, exp_r.id, exp_r.weight, exp_r.total, exp_r.count,
                       exp_r.last);
              $display("  got kind=%0d id=%h wt=%h total=%0d count=%0d last=%b",
                       kind, out_id, out_weight, total_weight, entry_count, last);
            end
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_AUTO_EN) auto_en = cfg_data[0];
        else weight_cap = cfg_data[TOTAL_W-1:0];
      end
      if (in_valid && in_ready)
        run_command(cmd, item_id, item_weight);
    end
    pending <= fifo_results_q.size();
  end

endmodule

[sim/testbench.sv]
// Top of the weighted drop-head FIFO bench: clock, reset, command traffic and verdict.
module testbench
  import wdh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         SETTLE      = 50;
  localparam int         PHASE_ITEMS = 46;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          cmd;
  logic [15:0]         item_id;
  logic [15:0]         item_weight;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   kind;
  logic [OUT_ID_W-1:0] out_id;
  logic [OUT_WT_W-1:0] out_weight;
  logic [TOTAL_W-1:0]  total_weight;
  logic [COUNT_W-1:0]  entry_count;
  logic                last;
  int                  failures;
  int                  pending;

  bit quiet;
  bit long_hold_go;
  int cycle_count;

  logic [15:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                               16'h00FF, 16'h5A5A, 16'hA5A5, 16'h1234};

  weighted_drop_head_fifo uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .item_id(item_id), .item_weight(item_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_id(out_id), .out_weight(out_weight),
    .total_weight(total_weight), .entry_count(entry_count), .last(last)
  );

  wdh_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .item_id(item_id), .item_weight(item_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_id(out_id), .out_weight(out_weight),
    .total_weight(total_weight), .entry_count(entry_count), .last(last),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // holds the payload until the transfer happens; leaves in_valid high
  task automatic offer(input logic [1:0] c, input logic [15:0] id, input logic [15:0] wt);
    in_valid    <= 1'b1;
    cmd         <= c;
    item_id     <= id;
    item_weight <= wt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and wait until every result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [TOTAL_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_AUTO_EN;
    cfg_data  <= CFG_W'(en);
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= CFG_W'(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item(input int add_pct, output logic [1:0] c,
                             output logic [15:0] id, output logic [15:0] wt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) c = CMD_UNUSED;
    else if (r < 3 + add_pct) c = CMD_ADD;
    else if (r < 3 + add_pct + (97 - add_pct) / 2) c = CMD_DEPART;
    else c = CMD_FIND;
    // mostly pooled ids so finds hit and duplicates show up
    if ($urandom_range(0, 3) == 0) id = 16'($urandom);
    else id = id_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 9))
      0:       wt = 16'h0000;
      1:       wt = 16'hFFFF;
      2, 3, 4: wt = 16'($urandom);
      default: wt = 16'($urandom_range(0, 5000));
    endcase
  endtask

  // receiver side: random ready bursts, one long hold on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_go) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_go = 0;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 1) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("weighted_drop_head_fifo verification failed");
    $finish;
  end

  initial begin
    logic [1:0]         c;
    logic [15:0]        id;
    logic [15:0]        wt;
    logic               en;
    logic [TOTAL_W-1:0] cap;
    int                 add_pct;
    int                 gap_pct;
    int                 sent;

    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_AUTO_EN;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cmd         <= CMD_ADD;
    item_id     <= '0;
    item_weight <= '0;
    quiet        = 0;
    long_hold_go = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_config(1'b0, TOTAL_MAX);

    // directed: empty cases, extremes, ignored code, fill to full
    offer(CMD_DEPART, 16'h0000, 16'h0000);
    offer(CMD_FIND, 16'hFFFF, 16'h0000);
    offer(CMD_ADD, 16'h0000, 16'h0000);
    offer(CMD_ADD, 16'hFFFF, 16'hFFFF);
    offer(CMD_FIND, 16'hFFFF, 16'h0F0F);
    offer(CMD_FIND, 16'h0000, 16'hFFFF);
    offer(CMD_FIND, 16'h1234, 16'h0000);
    offer(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    offer(CMD_DEPART, 16'hFFFF, 16'hFFFF);
    offer(CMD_DEPART, 16'h0000, 16'h0000);
    for (int i = 0; i < 16; i++)
      offer(CMD_ADD, id_pool[i % 8], 16'hFFFF);
    offer(CMD_ADD, 16'hBEEF, 16'h0001);    // full store
    offer(CMD_FIND, 16'h5A5A, 16'h0000);   // first of two matches
    drain();

    // limit of zero flushes the whole store ahead of one add
    set_config(1'b1, '0);
    offer(CMD_ADD, 16'h00AA, 16'h0001);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin en = 1'b0; cap = TOTAL_MAX; add_pct = 60; gap_pct = 20; end
        1: begin en = 1'b1; cap = '0; add_pct = 50; gap_pct = 0; end
        2: begin en = 1'b1; cap = TOTAL_MAX; add_pct = 65; gap_pct = 15; end
        3: begin
          en = 1'b1; cap = TOTAL_W'($urandom_range(60000, 300000));
          add_pct = 55; gap_pct = 25;
        end
        4: begin en = 1'b0; cap = '0; add_pct = 70; gap_pct = 10; end
        5: begin
          en = 1'b1; cap = TOTAL_W'($urandom_range(0, 1048575));
          add_pct = 45; gap_pct = 30;
        end
        default: begin
          en = 1'b1; cap = TOTAL_W'(200000); add_pct = 55; gap_pct = 0;
        end
      endcase
      set_config(en, cap);
      if (ph == 6) quiet = 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_item(add_pct, c, id, wt);
        offer(c, id, wt);
        if (c != CMD_UNUSED) sent++;
        if (ph == 3 && sent == 10) long_hold_go = 1;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
          sender_gap($urandom_range(1, 18));
      end
      drain();
    end

    if (failures == 0)
      $display("weighted_drop_head_fifo verification clean");
    else
      $display("weighted_drop_head_fifo verification failed");
    $finish;
  end

endmodule
